>>> rtl/dq_pkg.sv
// Package for the double-ended queue: sizes, request codes, transaction
// structs and the store-width conversion functions.
// No dependencies; used by dq_cell and double_ended_queue.
package dq_pkg;

    // Number of cells in the chain and width of one stored value.
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;

    // Width of the occupancy counter, which must also hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths of the transactions.
    localparam int VALUE_W   = 32;
    localparam int REQ_W     = 3;
    localparam int OUT_CNT_W = 7;

    typedef logic [DATA_WIDTH-1:0] dq_data_t;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_REM_HEAD = 3'd2,
        REQ_REM_TAIL = 3'd3,
        REQ_CLEAR    = 3'd4
    } dq_req_t;

    // Request transaction.
    typedef struct packed {
        logic [REQ_W-1:0]          req_type;
        logic signed [VALUE_W-1:0] value;
    } dq_in_t;

    // Response transaction.
    typedef struct packed {
        logic signed [VALUE_W-1:0] head_value;
        logic signed [VALUE_W-1:0] tail_value;
        logic [OUT_CNT_W-1:0]      count;
        logic                      is_empty;
        logic                      overflow;
    } dq_out_t;

    // Operation broadcast from the control to every cell in the chain.
    typedef struct packed {
        logic     ins_head;
        logic     ins_tail;
        logic     rem_head;
        logic     rem_tail;
        logic     clr;
        dq_data_t value;
    } dq_ctrl_t;

    // Keep the low DATA_WIDTH bits of a sign-extended request value.
    function automatic dq_data_t to_store(logic signed [VALUE_W-1:0] v);
        logic signed [63:0] wide;
        wide = 64'(v);
        return wide[DATA_WIDTH-1:0];
    endfunction

    // Sign-extend a stored value from DATA_WIDTH bits and keep 32 bits.
    function automatic logic signed [VALUE_W-1:0] from_store(dq_data_t d);
        logic signed [DATA_WIDTH-1:0] s;
        logic signed [63:0]           wide;
        s    = d;
        wide = 64'(s);
        return wide[VALUE_W-1:0];
    endfunction

endpackage

>>> rtl/dq_cell.sv
// One cell of the queue chain: a valid bit and a stored value, which move
// to the neighbouring cell on head inserts and head removals.
// Depends on dq_pkg.
module dq_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  dq_pkg::dq_ctrl_t ctrl,
    input  logic             left_valid,
    input  dq_pkg::dq_data_t left_data,
    input  logic             right_valid,
    input  dq_pkg::dq_data_t right_data,
    output logic             valid,
    output dq_pkg::dq_data_t data,
    output dq_pkg::dq_data_t tail_data
);
    import dq_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    dq_data_t data_reg;
    dq_data_t data_next;

    // Next state of the cell for the operation in progress.
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.ins_head)
        begin
            // Whole chain shifts one place towards the tail.
            valid_next = left_valid;
            data_next  = left_data;
        end
        else if (ctrl.ins_tail)
        begin
            // The first empty cell takes the new value.
            if (!valid_reg && left_valid)
            begin
                valid_next = 1'b1;
                data_next  = ctrl.value;
            end
        end
        else if (ctrl.rem_head)
        begin
            // Whole chain shifts one place towards the head.
            valid_next = right_valid;
            data_next  = right_data;
        end
        else if (ctrl.rem_tail)
        begin
            // The last occupied cell lets go of its value.
            valid_next = valid_reg && right_valid;
        end
    end

    // Occupancy bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored value; meaningless while the cell is empty.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid     = valid_reg;
    assign data      = data_reg;
    // The tail cell is the last occupied one; all others contribute zero.
    assign tail_data = (valid_reg && !right_valid) ? data_reg : '0;

endmodule

>>> rtl/double_ended_queue.sv
// An accepted request is first held as pending; its response is then loaded into the response register.
// Throughput: one transaction per cycle while rsp_stall is low, set by the response capture stage
// that samples the cell chain after each update.
// Reset clears the count, the cell valid bits and both handshakes; stored
// values are not reset and are never reported until written.
// Depends on dq_pkg and dq_cell.
module double_ended_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  dq_pkg::dq_in_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output dq_pkg::dq_out_t rsp
);
    import dq_pkg::*;

    logic             accept;
    logic             load;
    logic             full;
    logic             empty;
    dq_ctrl_t         ctrl;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             pend_reg;
    logic             pend_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    dq_out_t          rsp_reg;
    dq_out_t          rsp_next;
    logic             cell_valid [DEPTH];
    dq_data_t         cell_data [DEPTH];
    dq_data_t         cell_tail [DEPTH];
    dq_data_t         tail_sel;

    // Handshake: the response register is freed or loaded as a new
    // transaction arrives, so a request may follow in every cycle while rsp_stall is low.
    assign load      = pend_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = pend_reg && !load;
    assign accept    = req_valid && !req_stall;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    // Decode the accepted request into the operation for the cells.
    always_comb
    begin
        ctrl          = '0;
        ctrl.value    = to_store(req.value);
        count_next    = count_reg;
        ovf_next      = 1'b0;
        if (accept)
        begin
            case (dq_req_t'(req.req_type))
                REQ_INS_HEAD:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.ins_head = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                REQ_INS_TAIL:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        ctrl.ins_tail = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                REQ_REM_HEAD:
                begin
                    if (!empty)
                    begin
                        ctrl.rem_head = 1'b1;
                        count_next    = count_reg - 1'b1;
                    end
                end
                REQ_REM_TAIL:
                begin
                    if (!empty)
                    begin
                        ctrl.rem_tail = 1'b1;
                        count_next    = count_reg - 1'b1;
                    end
                end
                REQ_CLEAR:
                begin
                    ctrl.clr   = 1'b1;
                    count_next = '0;
                end
                default:
                begin
                    // Unused codes leave the queue as it is.
                end
            endcase
        end
    end

    // The chain of cells; cell 0 holds the head.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic     left_valid;
        dq_data_t left_data;
        logic     right_valid;
        dq_data_t right_data;

        if (i == 0)
        begin : g_first
            assign left_valid = 1'b1;
            assign left_data  = ctrl.value;
        end
        else
        begin : g_inner_left
            assign left_valid = cell_valid[i-1];
            assign left_data  = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_valid = 1'b0;
            assign right_data  = '0;
        end
        else
        begin : g_inner_right
            assign right_valid = cell_valid[i+1];
            assign right_data  = cell_data[i+1];
        end

        dq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .left_valid  (left_valid),
            .left_data   (left_data),
            .right_valid (right_valid),
            .right_data  (right_data),
            .valid       (cell_valid[i]),
            .data        (cell_data[i]),
            .tail_data   (cell_tail[i])
        );
    end

    // Only the tail cell drives a non-zero value, so an OR picks it out.
    always_comb
    begin
        tail_sel = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_sel = tail_sel | cell_tail[i];
        end
    end

    // Response built from the settled chain.
    always_comb
    begin
        rsp_next            = rsp_reg;
        rsp_next.head_value = cell_valid[0] ? from_store(cell_data[0]) : '0;
        rsp_next.tail_value = from_store(tail_sel);
        rsp_next.count      = OUT_CNT_W'(count_reg);
        rsp_next.is_empty   = empty;
        rsp_next.overflow   = ovf_reg;
    end

    // Pending and response-valid flags.
    always_comb
    begin
        pend_next = pend_reg;
        if (accept)
        begin
            pend_next = 1'b1;
        end
        else if (load)
        begin
            pend_next = 1'b0;
        end

        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ovf_reg <= ovf_next;
        end
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
